[rtl/core/adc_port_average_change_report_macros.svh]
// assertion macros shared by the averaging change reporter
// no dependencies; included by files that carry concurrent checks
`ifndef ADC_PORT_AVERAGE_CHANGE_REPORT_MACROS_SVH
`define ADC_PORT_AVERAGE_CHANGE_REPORT_MACROS_SVH

// same-cycle implication
`define APAC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("apac check failed");

// next-cycle implication
`define APAC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("apac check failed");

`endif

[rtl/core/apac_pkg.sv]
// constants, codes and shared types of the averaging change reporter
// no dependencies
package apac_pkg;

  localparam int NUM_PORTS           = 14;
  localparam int SAMPLES_PER_AVERAGE = 8;

  localparam int PORT_W  = 4;
  localparam int SAMPLE_W = 10;
  localparam int VALUE_W = 11;
  localparam int TYPES_W = 42;
  localparam int KIND_W  = 3;

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);

  localparam logic [TYPES_W-1:0] TYPES_RESET = 42'd1256584717458;

  localparam logic [KIND_W-1:0] KIND_FADER_BYTE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE_VOLUME = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BYTE_RAW    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FADER_WORD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WORD_VOLUME = 3'd4;
  localparam logic [KIND_W-1:0] KIND_WORD_RAW    = 3'd5;

  localparam int BYTE_CHANGE_MIN = 4;
  localparam int FADER_DIV       = 125;
  localparam int FADER_STEPS     = 8;
  localparam int FADER_BYTE_MIN  = 2;
  localparam int FADER_BYTE_MAX  = 127;
  localparam int BYTE_FULL       = 255;
  localparam int BVOL_LOW        = 124;
  localparam int BVOL_HIGH       = 130;
  localparam int BVOL_CENTER     = 127;
  localparam int FADER_WORD_MIN  = 8;
  localparam int WORD_FULL       = 1024;
  localparam int WVOL_LOW        = 506;
  localparam int WVOL_HIGH       = 518;
  localparam int WVOL_CENTER     = 512;

  typedef struct packed {
    logic [PORT_W-1:0]   port;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                report;
    logic [PORT_W-1:0]   port;
    logic [SAMPLE_W-1:0] avg;
    logic [KIND_W-1:0]   kind;
  } decision_t;

endpackage

[rtl/core/apac_sample_if.sv]
// sample channel: valid/ready with port number and converter reading
// depends on apac_pkg
interface apac_sample_if;
  logic                         valid;
  logic                         ready;
  logic [apac_pkg::PORT_W-1:0]   port;
  logic [apac_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output port, output sample, input ready);
  modport sink (input valid, input port, input sample, output ready);
endinterface

[rtl/core/apac_report_if.sv]
// report channel: valid/ready with port, scaled value and word flag
// depends on apac_pkg
interface apac_report_if;
  logic                        valid;
  logic                        ready;
  logic [apac_pkg::PORT_W-1:0]  report_port;
  logic [apac_pkg::VALUE_W-1:0] report_value;
  logic                        is_word;

  modport source (output valid, output report_port, output report_value, output is_word,
                  input ready);
  modport sink (input valid, input report_port, input report_value, input is_word,
                output ready);
endinterface

[rtl/core/apac_cfg_if.sv]
// configuration write channel: valid/ready with port type register data
// depends on apac_pkg
interface apac_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [apac_pkg::TYPES_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/apac_accum.sv]
// per-port running sums, sample counts and last reported averages, change decision
// depends on apac_pkg and adc_port_average_change_report_macros.svh
`include "adc_port_average_change_report_macros.svh"

module apac_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  input  logic                         go,
  input  apac_pkg::item_t              item,
  input  logic [apac_pkg::TYPES_W-1:0] port_types,
  output apac_pkg::decision_t          dec
);

  logic [apac_pkg::CNT_W-1:0]    sample_count  [apac_pkg::NUM_PORTS];
  logic [apac_pkg::SUM_W-1:0]    running_sum   [apac_pkg::NUM_PORTS];
  logic [apac_pkg::SAMPLE_W-1:0] last_reported [apac_pkg::NUM_PORTS];

  logic [apac_pkg::IDX_W-1:0]    idx;
  logic                          in_range;
  logic                          done;
  logic [apac_pkg::SUM_W-1:0]    sum_next;
  logic [apac_pkg::SAMPLE_W-1:0] avg;
  logic [apac_pkg::SAMPLE_W-1:0] diff;
  logic [apac_pkg::TYPES_W-1:0]  types_shifted;
  logic [apac_pkg::KIND_W-1:0]   kind;
  logic                          changed;

  always_comb begin
    idx      = item.port[apac_pkg::IDX_W-1:0];
    in_range = (5'(item.port) < 5'(apac_pkg::NUM_PORTS));
    done     = (sample_count[idx] == apac_pkg::CNT_W'(apac_pkg::SAMPLES_PER_AVERAGE - 1));
    sum_next = running_sum[idx] + apac_pkg::SUM_W'(item.sample);
    avg      = apac_pkg::SAMPLE_W'(sum_next / apac_pkg::SAMPLES_PER_AVERAGE);
    diff     = (avg > last_reported[idx]) ? avg - last_reported[idx]
                                          : last_reported[idx] - avg;
    types_shifted = port_types >> (6'(item.port) * 6'd3);
    kind     = types_shifted[apac_pkg::KIND_W-1:0];
    if (kind < apac_pkg::KIND_FADER_WORD) begin
      changed = (diff > apac_pkg::SAMPLE_W'(apac_pkg::BYTE_CHANGE_MIN));
    end else if (kind <= apac_pkg::KIND_WORD_RAW) begin
      changed = (diff != '0);
    end else begin
      changed = 1'b0;
    end
    dec.report = valid && in_range && done && changed;
    dec.port   = item.port;
    dec.avg    = avg;
    dec.kind   = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < apac_pkg::NUM_PORTS; i++) begin
        sample_count[i]  <= '0;
        running_sum[i]   <= '0;
        last_reported[i] <= '0;
      end
    end else if (go && in_range) begin
      if (done) begin
        sample_count[idx] <= '0;
        running_sum[idx]  <= '0;
        if (dec.report) begin
          last_reported[idx] <= avg;
        end
      end else begin
        sample_count[idx] <= sample_count[idx] + 1'b1;
        running_sum[idx]  <= sum_next;
      end
    end
  end

  `APAC_ASSERT_IMPLY(a_report_legal, clk, rst, dec.report, in_range && done && (kind <= apac_pkg::KIND_WORD_RAW))
  `APAC_ASSERT_NEXT(a_count_cleared, clk, rst, go && in_range && done, sample_count[$past(idx)] == '0)
  `APAC_ASSERT_NEXT(a_last_updated, clk, rst, go && dec.report, last_reported[$past(idx)] == $past(avg))

endmodule

[rtl/core/apac_scale.sv]
// scaling of an average by port type: fader, volume with center dead band, raw
// depends on apac_pkg
module apac_scale (
  input  logic [apac_pkg::KIND_W-1:0]   kind,
  input  logic [apac_pkg::SAMPLE_W-1:0] avg,
  output logic [apac_pkg::VALUE_W-1:0]  value,
  output logic                          is_word
);

  logic [6:0]                     byte_avg;
  logic [7:0]                     fader_byte;
  logic [7:0]                     byte_vol;
  logic [3:0]                     steps;
  logic [apac_pkg::VALUE_W-1:0]   fader_word;
  logic [apac_pkg::VALUE_W-1:0]   word_vol;

  always_comb begin
    byte_avg   = avg[apac_pkg::SAMPLE_W-1:3];
    // v*126/125 is v plus floor(v/125)
    fader_byte = {1'b0, byte_avg} + 8'(byte_avg >= 7'(apac_pkg::FADER_DIV));
    byte_vol   = 8'(apac_pkg::BYTE_FULL) - avg[apac_pkg::SAMPLE_W-1:2];
    steps      = '0;
    for (int k = 1; k <= apac_pkg::FADER_STEPS; k++) begin
      steps = steps + 4'(avg >= apac_pkg::SAMPLE_W'(apac_pkg::FADER_DIV * k));
    end
    fader_word = apac_pkg::VALUE_W'(avg) + apac_pkg::VALUE_W'(steps);
    word_vol   = apac_pkg::VALUE_W'(apac_pkg::WORD_FULL) - apac_pkg::VALUE_W'(avg);

    case (kind)
      apac_pkg::KIND_FADER_BYTE: begin
        if (fader_byte < 8'(apac_pkg::FADER_BYTE_MIN)) begin
          value = '0;
        end else if (fader_byte > 8'(apac_pkg::FADER_BYTE_MAX)) begin
          value = apac_pkg::VALUE_W'(apac_pkg::FADER_BYTE_MAX);
        end else begin
          value = apac_pkg::VALUE_W'(fader_byte);
        end
      end
      apac_pkg::KIND_BYTE_VOLUME: begin
        if (byte_vol > 8'(apac_pkg::BVOL_LOW) && byte_vol < 8'(apac_pkg::BVOL_HIGH)) begin
          value = apac_pkg::VALUE_W'(apac_pkg::BVOL_CENTER);
        end else begin
          value = apac_pkg::VALUE_W'(byte_vol);
        end
      end
      apac_pkg::KIND_BYTE_RAW: begin
        value = apac_pkg::VALUE_W'(avg[apac_pkg::SAMPLE_W-1:2]);
      end
      apac_pkg::KIND_FADER_WORD: begin
        if (fader_word < apac_pkg::VALUE_W'(apac_pkg::FADER_WORD_MIN)) begin
          value = '0;
        end else if (fader_word > apac_pkg::VALUE_W'(apac_pkg::WORD_FULL)) begin
          value = apac_pkg::VALUE_W'(apac_pkg::WORD_FULL);
        end else begin
          value = fader_word;
        end
      end
      apac_pkg::KIND_WORD_VOLUME: begin
        if (word_vol > apac_pkg::VALUE_W'(apac_pkg::WVOL_LOW) &&
            word_vol < apac_pkg::VALUE_W'(apac_pkg::WVOL_HIGH)) begin
          value = apac_pkg::VALUE_W'(apac_pkg::WVOL_CENTER);
        end else begin
          value = word_vol;
        end
      end
      apac_pkg::KIND_WORD_RAW: begin
        value = apac_pkg::VALUE_W'(avg);
      end
      default: begin
        value = '0;
      end
    endcase
    is_word = (kind >= apac_pkg::KIND_FADER_WORD);
  end

endmodule

[rtl/core/adc_port_average_change_report.sv]
// Averaging change reporter: accepts one converter sample per clock on the sample channel
// and, when a port completes its averaging window with a large enough move, delivers one
// report after the sample transfer, through the input register and then the result register.
// Sustained rate is one sample per cycle; it is set by the read-modify-write of the
// per-port sum, count and last value. A sample that would report stalls only while
// the result register is full and not taken. Port types are written on the cfg channel.
// depends on apac_pkg, the channel interfaces, apac_accum and apac_scale
module adc_port_average_change_report (
  input  logic          clk,
  input  logic          rst,
  apac_sample_if.sink   samples,
  apac_report_if.source reports,
  apac_cfg_if.sink      cfg
);

  logic [apac_pkg::TYPES_W-1:0]  port_types;
  logic                          s1_valid;
  apac_pkg::item_t               s1_item;
  apac_pkg::decision_t           dec;
  logic                          out_free;
  logic                          go;
  logic [apac_pkg::VALUE_W-1:0]  value;
  logic                          word;
  logic                          out_valid;
  logic [apac_pkg::PORT_W-1:0]   out_port;
  logic [apac_pkg::VALUE_W-1:0]  out_value;
  logic                          out_word;

  assign cfg.ready     = 1'b1;
  assign out_free      = !out_valid || reports.ready;
  assign go            = s1_valid && (!dec.report || out_free);
  assign samples.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_types <= apac_pkg::TYPES_RESET;
    end else if (cfg.valid) begin
      port_types <= cfg.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s1_item.port   <= samples.port;
      s1_item.sample <= samples.sample;
    end
  end

  apac_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .valid      (s1_valid),
    .go         (go),
    .item       (s1_item),
    .port_types (port_types),
    .dec        (dec)
  );

  apac_scale u_scale (
    .kind    (dec.kind),
    .avg     (dec.avg),
    .value   (value),
    .is_word (word)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= go && dec.report;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && go && dec.report) begin
      out_port  <= dec.port;
      out_value <= value;
      out_word  <= word;
    end
  end

  assign reports.valid        = out_valid;
  assign reports.report_port  = out_port;
  assign reports.report_value = out_value;
  assign reports.is_word      = out_word;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// testbench for the averaging change reporter: drives samples and port type writes,
// predicts every report in a small scoreboard class and checks each report transfer
// depends on apac_pkg, the three channel interfaces and adc_port_average_change_report
module testbench;
  import apac_pkg::*;

  // longest quiet stretch of a correct run is the output hold-off, plus a few sender gaps
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int KIND_CODES    = 1 << KIND_W;

  typedef struct {
    logic [PORT_W-1:0]  port;
    logic [VALUE_W-1:0] value;
    logic               is_word;
  } report_t;

  class port_average_tracker;
    logic [TYPES_W-1:0]  port_types;
    int unsigned         taken [NUM_PORTS];
    logic [SUM_W-1:0]    sums [NUM_PORTS];
    logic [SAMPLE_W-1:0] last_avg [NUM_PORTS];
    report_t             expected_reports [$];

    function new();
      port_types = TYPES_RESET;
      for (int p = 0; p < NUM_PORTS; p++) begin
        taken[p] = 0;
        sums[p] = '0;
        last_avg[p] = '0;
      end
    endfunction

    function void set_types(logic [TYPES_W-1:0] value);
      port_types = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function logic [VALUE_W-1:0] scaled(logic [KIND_W-1:0] kind, logic [SAMPLE_W-1:0] avg);
      int unsigned a;
      int unsigned v;
      a = avg;
      case (kind)
        KIND_FADER_BYTE: begin
          v = ((a >> 3) * (FADER_DIV + 1)) / FADER_DIV;
          if (v < FADER_BYTE_MIN) v = 0;
          else if (v > FADER_BYTE_MAX) v = FADER_BYTE_MAX;
        end
        KIND_BYTE_VOLUME: begin
          v = BYTE_FULL - (a >> 2);
          if (v > BVOL_LOW && v < BVOL_HIGH) v = BVOL_CENTER;
        end
        KIND_BYTE_RAW: v = a >> 2;
        KIND_FADER_WORD: begin
          v = (a * (FADER_DIV + 1)) / FADER_DIV;
          if (v < FADER_WORD_MIN) v = 0;
          else if (v > WORD_FULL) v = WORD_FULL;
        end
        KIND_WORD_VOLUME: begin
          v = WORD_FULL - a;
          if (v > WVOL_LOW && v < WVOL_HIGH) v = WVOL_CENTER;
        end
        default: v = a;
      endcase
      return v[VALUE_W-1:0];
    endfunction

    function void note_sample(logic [PORT_W-1:0] port, logic [SAMPLE_W-1:0] sample);
      logic [KIND_W-1:0]   kind;
      logic [SAMPLE_W-1:0] avg;
      int unsigned         diff;
      bit                  moved;
      report_t             rep;
      if (port >= NUM_PORTS) return;
      sums[port] = sums[port] + sample;
      taken[port]++;
      if (taken[port] < SAMPLES_PER_AVERAGE) return;
      avg = sums[port] / SAMPLES_PER_AVERAGE;
      sums[port] = '0;
      taken[port] = 0;
      kind = port_types[KIND_W*port +: KIND_W];
      diff = (avg > last_avg[port]) ? avg - last_avg[port] : last_avg[port] - avg;
      if (kind <= KIND_BYTE_RAW) moved = diff > BYTE_CHANGE_MIN;
      else if (kind <= KIND_WORD_RAW) moved = diff != 0;
      else moved = 0;
      if (!moved) return;
      last_avg[port] = avg;
      rep.port = port;
      rep.value = scaled(kind, avg);
      rep.is_word = kind >= KIND_FADER_WORD;
      expected_reports.push_back(rep);
    endfunction

    function string check_report(logic [PORT_W-1:0] port, logic [VALUE_W-1:0] value,
                                 logic is_word);
      report_t want;
      string   msg;
      msg = "";
      if (expected_reports.size() == 0)
        return $sformatf("unexpected report port %0d value %0d word %0d", port, value, is_word);
      want = expected_reports.pop_front();
      if (port !== want.port) msg = {msg, $sformatf(" port %0d/%0d", port, want.port)};
      if (value !== want.value) msg = {msg, $sformatf(" value %0d/%0d", value, want.value)};
      if (is_word !== want.is_word) msg = {msg, $sformatf(" word %0d/%0d", is_word, want.is_word)};
      if (msg != "") msg = {"report differs (got/expected):", msg};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst;

  apac_sample_if sample_ch ();
  apac_report_if report_ch ();
  apac_cfg_if    cfg_ch ();

  adc_port_average_change_report dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .reports (report_ch),
    .cfg     (cfg_ch)
  );

  port_average_tracker sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int n_samples = 0;
  int n_reports = 0;
  int n_writes = 0;

  logic [SAMPLE_W-1:0] window_samples [NUM_PORTS][SAMPLES_PER_AVERAGE];
  int                  window_pos [NUM_PORTS];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    string msg;
    bit    moved;
    if (!rst) begin
      moved = 0;
      if (report_ch.valid && report_ch.ready) begin
        msg = sb.check_report(report_ch.report_port, report_ch.report_value, report_ch.is_word);
        if (msg != "") flag_mismatch(msg);
        n_reports++;
        moved = 1;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        sb.note_sample(sample_ch.port, sample_ch.sample);
        n_samples++;
        moved = 1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_types(cfg_ch.data);
        n_writes++;
        moved = 1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // report receiver with random stalls and an occasional long hold-off
  initial begin
    report_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        report_ch.ready = 0;
        hold_left--;
      end else begin
        report_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic next_slot();
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid = 0;
      @(negedge clk);
    end
  endtask

  task automatic offer_sample(logic [PORT_W-1:0] port, logic [SAMPLE_W-1:0] sample);
    sample_ch.port = port;
    sample_ch.sample = sample;
    sample_ch.valid = 1;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    sample_ch.valid = 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_types(logic [TYPES_W-1:0] value);
    drain_reports();
    @(negedge clk);
    cfg_ch.data = value;
    cfg_ch.valid = 1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  // mostly whole averaging windows aimed near, at or far from the last report,
  // with some corrupted samples and some samples for ports that do not exist
  task automatic run_random(int n_items);
    int                  done;
    int                  p;
    int                  mode;
    int                  target;
    int                  span;
    int                  j;
    int                  r;
    logic [SAMPLE_W-1:0] s;
    done = 0;
    while (done < n_items) begin
      next_slot();
      if ($urandom_range(99) < 8) begin
        offer_sample(PORT_W'($urandom_range((1 << PORT_W) - 1, NUM_PORTS)),
                     SAMPLE_W'($urandom()));
      end else begin
        p = $urandom_range(NUM_PORTS - 1);
        if (window_pos[p] == SAMPLES_PER_AVERAGE) begin
          mode = $urandom_range(9);
          if (mode < 4) begin
            target = int'(sb.last_avg[p]) + int'($urandom_range(12)) - 6;
            if (target < 0) target = 0;
            if (target > SAMPLE_MAX) target = SAMPLE_MAX;
          end else if (mode < 6) begin
            target = $urandom_range(1) ? SAMPLE_MAX : 0;
          end else begin
            target = $urandom_range(SAMPLE_MAX);
          end
          span = (target < SAMPLE_MAX - target) ? target : SAMPLE_MAX - target;
          if (span > 40) span = 40;
          r = $urandom_range(SAMPLES_PER_AVERAGE - 1);
          if (target + r > SAMPLE_MAX) r = SAMPLE_MAX - target;
          for (int k = 0; k < SAMPLES_PER_AVERAGE; k++) window_samples[p][k] = SAMPLE_W'(target);
          for (int k = 0; k + 1 < SAMPLES_PER_AVERAGE; k += 2) begin
            j = $urandom_range(span);
            window_samples[p][k] = SAMPLE_W'(target + j);
            window_samples[p][k+1] = SAMPLE_W'(target - j);
          end
          if (SAMPLES_PER_AVERAGE > 1)
            window_samples[p][1] = window_samples[p][1] + SAMPLE_W'(r);
          window_pos[p] = 0;
        end
        s = window_samples[p][window_pos[p]];
        if ($urandom_range(99) < 8) s = SAMPLE_W'($urandom());
        window_pos[p]++;
        offer_sample(PORT_W'(p), s);
        done++;
      end
    end
  endtask

  initial begin : stimulus
    logic [TYPES_W-1:0] types;
    rst = 1;
    sample_ch.valid = 0;
    sample_ch.port = '0;
    sample_ch.sample = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    for (int p = 0; p < NUM_PORTS; p++) window_pos[p] = SAMPLES_PER_AVERAGE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    tx_idle_pct = 10;
    rx_idle_pct = 70;

    // default types: ignored ports, a full-scale window, an average just inside the dead zone
    next_slot();
    offer_sample(PORT_W'((1 << PORT_W) - 1), SAMPLE_W'(SAMPLE_MAX));
    for (int k = 0; k < SAMPLES_PER_AVERAGE; k++) begin
      next_slot();
      offer_sample(PORT_W'(NUM_PORTS - 1), SAMPLE_W'(SAMPLE_MAX));
    end
    next_slot();
    offer_sample(PORT_W'(NUM_PORTS), '0);
    for (int k = 0; k < SAMPLES_PER_AVERAGE; k++) begin
      next_slot();
      offer_sample('0, (k == SAMPLES_PER_AVERAGE - 1) ?
                   SAMPLE_W'(BYTE_CHANGE_MIN * SAMPLES_PER_AVERAGE + SAMPLES_PER_AVERAGE - 1) :
                   '0);
    end

    types = '0;
    for (int p = 0; p < NUM_PORTS; p++) types[KIND_W*p +: KIND_W] = KIND_W'(p % KIND_CODES);
    write_types(types);
    run_random(20);
    hold_request = 1;
    run_random(230);

    tx_idle_pct = 70;
    rx_idle_pct = 10;
    write_types('0);
    run_random(150);
    write_types('1);
    run_random(80);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int p = 0; p < NUM_PORTS; p++)
      types[KIND_W*p +: KIND_W] = KIND_W'($urandom_range(KIND_CODES - 1));
    write_types(types);
    run_random(200);
    for (int p = 0; p < NUM_PORTS; p++)
      types[KIND_W*p +: KIND_W] = KIND_W'((p + 3) % KIND_CODES);
    write_types(types);
    run_random(120);
    write_types(TYPES_RESET);
    run_random(100);

    drain_reports();
    $display("covered %0d sample transfers, %0d reports and %0d type writes", n_samples,
             n_reports, n_writes);
    $display("all port types incl. invalid, three idle patterns and one long report stall");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
